[rtl/jsu_pkg.sv]
// Package for the JSON string unescaper: payload types, result kinds, decoder modes
// and the character, UTF-8 and queue constants used by the decoder. No dependencies.
`default_nettype none

package jsu_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       text_ended;
   } req_type;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0] out_byte;
      kind_type   kind;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      MODE_PLAIN  = 2'd0,
      MODE_ESCAPE = 2'd1,
      MODE_HEX    = 2'd2
   } mode_type;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
   localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
   localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
   localparam logic [7:0] CHAR_LOWER_B   = 8'h62;
   localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
   localparam logic [7:0] CHAR_LOWER_U   = 8'h75;

   localparam logic [7:0] CODE_LF = 8'h0A;
   localparam logic [7:0] CODE_HT = 8'h09;
   localparam logic [7:0] CODE_CR = 8'h0D;
   localparam logic [7:0] CODE_BS = 8'h08;
   localparam logic [7:0] CODE_FF = 8'h0C;

   localparam logic [15:0] UTF8_ONE_LIMIT = 16'h0080;
   localparam logic [15:0] UTF8_TWO_LIMIT = 16'h0800;
   localparam logic [7:0]  UTF8_LEAD_TWO   = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD_THREE = 8'hE0;
   localparam logic [7:0]  UTF8_CONT       = 8'h80;
   localparam logic [7:0]  UTF8_CONT_MASK  = 8'h3F;

   // Output queue: one item can produce three result bytes.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned MAX_RESULTS = 3;

   // Hex digit value in the low four bits; bit 4 set when the byte is no hex digit.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = {1'b0, 4'(c - 8'h61 + 8'd10)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = {1'b0, 4'(c - 8'h41 + 8'd10)};
      end else begin
         v = 5'h10;
      end
      return v;
   endfunction

endpackage

`default_nettype wire

[rtl/jsu_stream_if.sv]
// Valid/ready stream channel carrying one payload item per handshake.
// The payload type is supplied by the user, normally a struct from jsu_pkg.
`default_nettype none

interface jsu_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/json_string_unescape_utf8.sv]
// JSON string body unescaper. Bytes of a string body (opening quote already taken) enter on
// req one item per cycle unless the input register is held, and are registered; the
// registered item is decoded, escapes and \uXXXX (as 1 to 3 UTF-8 bytes), into a 4-entry
// output queue that drives rsp one result per cycle while rsp is ready. The input register
// advances only when the queue has three free entries, so plain bytes flow at one per cycle
// while rsp is ready; a \u escape of two or three bytes holds the input till they drain.
// Depends on jsu_pkg and jsu_stream_if.
`default_nettype none

module json_string_unescape_utf8 (
   input  wire logic clock,
   input  wire logic reset,
   jsu_stream_if.sink   req,
   jsu_stream_if.source rsp
);
   import jsu_pkg::*;

   localparam int unsigned PtrWidth   = $clog2(QUEUE_DEPTH);
   localparam int unsigned CountWidth = $clog2(QUEUE_DEPTH + 1);

   // Input register
   logic       in_valid_ff, in_valid_in;
   req_type    in_data_ff;

   // Decoder state
   mode_type    mode_ff, mode_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [15:0] code_point_ff, code_point_in;

   // Output queue
   rsp_type                 queue_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;

   logic       advance;
   logic       pop;
   logic [1:0] push_n;

   rsp_type    res [MAX_RESULTS];
   logic [1:0] res_n;

   logic [7:0]  c;
   logic [4:0]  digit;
   logic [15:0] cp_new;

   assign c      = in_data_ff.in_byte;
   assign digit  = hex_value(c);
   assign cp_new = {code_point_ff[11:0], digit[3:0]};

   assign advance   = in_valid_ff &&
                      (count_ff <= CountWidth'(QUEUE_DEPTH - MAX_RESULTS));
   assign req.ready = !in_valid_ff || advance;
   assign in_valid_in = req.ready ? req.valid : in_valid_ff;

   assign rsp.valid   = (count_ff != '0);
   assign rsp.payload = queue_ff[rd_ptr_ff];
   assign pop         = rsp.valid && rsp.ready;
   assign push_n      = advance ? res_n : 2'd0;

   assign wr_ptr_in = wr_ptr_ff + PtrWidth'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PtrWidth'(pop);
   assign count_in  = count_ff + CountWidth'(push_n) - CountWidth'(pop);

   // Next state of the decoder.
   always_comb begin
      mode_in       = mode_ff;
      hex_count_in  = hex_count_ff;
      code_point_in = code_point_ff;
      if (advance) begin
         if (in_data_ff.text_ended) begin
            mode_in       = MODE_PLAIN;
            hex_count_in  = 2'd0;
            code_point_in = 16'd0;
         end else begin
            case (mode_ff)
               MODE_ESCAPE: begin
                  if (c == CHAR_LOWER_U) begin
                     mode_in       = MODE_HEX;
                     hex_count_in  = 2'd0;
                     code_point_in = 16'd0;
                  end else begin
                     mode_in = MODE_PLAIN;
                  end
               end
               MODE_HEX: begin
                  if (digit[4] || hex_count_ff == 2'd3) begin
                     mode_in       = MODE_PLAIN;
                     hex_count_in  = 2'd0;
                     code_point_in = 16'd0;
                  end else begin
                     hex_count_in  = hex_count_ff + 2'd1;
                     code_point_in = cp_new;
                  end
               end
               default: begin
                  if (c == CHAR_QUOTE) begin
                     mode_in       = MODE_PLAIN;
                     hex_count_in  = 2'd0;
                     code_point_in = 16'd0;
                  end else if (c == CHAR_BACKSLASH) begin
                     mode_in = MODE_ESCAPE;
                  end else begin
                     mode_in = MODE_PLAIN;
                  end
               end
            endcase
         end
      end
   end

   // Results produced by the registered item.
   always_comb begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res[i] = '{out_byte: 8'd0, kind: KIND_BYTE, last: 1'b0};
      end
      res_n = 2'd0;
      if (in_data_ff.text_ended) begin
         res[0] = '{out_byte: 8'd0, kind: KIND_ERROR, last: 1'b1};
         res_n  = 2'd1;
      end else begin
         case (mode_ff)
            MODE_ESCAPE: begin
               if (c != CHAR_LOWER_U) begin
                  res_n       = 2'd1;
                  res[0].last = 1'b1;
                  if (c == CHAR_LOWER_N) begin
                     res[0].out_byte = CODE_LF;
                  end else if (c == CHAR_LOWER_T) begin
                     res[0].out_byte = CODE_HT;
                  end else if (c == CHAR_LOWER_R) begin
                     res[0].out_byte = CODE_CR;
                  end else if (c == CHAR_LOWER_B) begin
                     res[0].out_byte = CODE_BS;
                  end else if (c == CHAR_LOWER_F) begin
                     res[0].out_byte = CODE_FF;
                  end else begin
                     res[0].out_byte = c;
                  end
               end
            end
            MODE_HEX: begin
               if (digit[4]) begin
                  res[0] = '{out_byte: 8'd0, kind: KIND_ERROR, last: 1'b1};
                  res_n  = 2'd1;
               end else if (hex_count_ff == 2'd3) begin
                  if (cp_new < UTF8_ONE_LIMIT) begin
                     res[0].out_byte = cp_new[7:0];
                     res[0].last     = 1'b1;
                     res_n           = 2'd1;
                  end else if (cp_new < UTF8_TWO_LIMIT) begin
                     res[0].out_byte = UTF8_LEAD_TWO | {3'd0, cp_new[10:6]};
                     res[1].out_byte = UTF8_CONT | ({2'd0, cp_new[5:0]} & UTF8_CONT_MASK);
                     res[1].last     = 1'b1;
                     res_n           = 2'd2;
                  end else begin
                     res[0].out_byte = UTF8_LEAD_THREE | {4'd0, cp_new[15:12]};
                     res[1].out_byte = UTF8_CONT | ({2'd0, cp_new[11:6]} & UTF8_CONT_MASK);
                     res[2].out_byte = UTF8_CONT | ({2'd0, cp_new[5:0]} & UTF8_CONT_MASK);
                     res[2].last     = 1'b1;
                     res_n           = 2'd3;
                  end
               end
            end
            default: begin
               if (c == CHAR_QUOTE) begin
                  res[0] = '{out_byte: 8'd0, kind: KIND_END, last: 1'b1};
                  res_n  = 2'd1;
               end else if (c != CHAR_BACKSLASH) begin
                  res[0] = '{out_byte: c, kind: KIND_BYTE, last: 1'b1};
                  res_n  = 2'd1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         mode_ff       <= MODE_PLAIN;
         hex_count_ff  <= 2'd0;
         code_point_ff <= 16'd0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         mode_ff       <= mode_in;
         hex_count_ff  <= hex_count_in;
         code_point_ff <= code_point_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_data_ff <= req.payload;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (2'(i) < push_n) begin
            queue_ff[wr_ptr_ff + PtrWidth'(i)] <= res[i];
         end
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(QUEUE_DEPTH))
      else $error("output queue count exceeds its depth");

   a_room_on_advance: assert property (@(posedge clock) disable iff (reset)
      advance |-> (CountWidth'(QUEUE_DEPTH) - count_ff) >= CountWidth'(res_n))
      else $error("decoded item pushed without room in the output queue");

   a_end_returns_plain: assert property (@(posedge clock) disable iff (reset)
      advance && in_data_ff.text_ended |=> mode_ff == MODE_PLAIN && hex_count_ff == 2'd0)
      else $error("decoder not back in plain mode after the text ended");

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.kind != KIND_BYTE |-> rsp.payload.last &&
         rsp.payload.out_byte == 8'd0)
      else $error("end or error result is not a final zero-byte result");

   a_hex_count_mode: assert property (@(posedge clock) disable iff (reset)
      hex_count_ff != 2'd0 |-> mode_ff == MODE_HEX)
      else $error("hex digit count held outside hex mode");
`endif

endmodule

`default_nettype wire

[tb/unescape_check.sv]
// Scoreboard for the JSON string unescaper: watches both channels, decodes each accepted item
// with its own copy of the escape and UTF-8 rules, and compares every result item in order.
// Depends on jsu_pkg.

module unescape_check (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  jsu_pkg::req_type req_item,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  jsu_pkg::rsp_type rsp_item,
   output int               pending,
   output int               fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import jsu_pkg::*;

   mode_type    decode_mode;
   logic [1:0]  digits_taken;
   logic [15:0] point_so_far;
   rsp_type     decoded_bytes[$];

   // Low four bits hold the digit value; bit 4 flags a byte that is no hex digit.
   function automatic logic [4:0] digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return {1'b0, c[3:0]};
      end
      if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
         return {1'b0, c[3:0] + 4'd9};
      end
      return 5'h10;
   endfunction

   function automatic rsp_type result_of(input logic [7:0] b, input kind_type k);
      rsp_type r;
      r.out_byte = b;
      r.kind = k;
      r.last = 1'b0;
      return r;
   endfunction

   task automatic back_to_plain();
      decode_mode = MODE_PLAIN;
      digits_taken = 2'd0;
      point_so_far = 16'h0000;
   endtask

   task automatic decode_item(input req_type item);
      rsp_type     made[$];
      logic [4:0]  digit;
      logic [15:0] point;
      if (item.text_ended) begin
         made = {made, result_of(8'h00, KIND_ERROR)};
         back_to_plain();
      end else begin
         case (decode_mode)
            MODE_ESCAPE: begin
               decode_mode = MODE_PLAIN;
               case (item.in_byte)
                  CHAR_LOWER_N: made = {made, result_of(CODE_LF, KIND_BYTE)};
                  CHAR_LOWER_T: made = {made, result_of(CODE_HT, KIND_BYTE)};
                  CHAR_LOWER_R: made = {made, result_of(CODE_CR, KIND_BYTE)};
                  CHAR_LOWER_B: made = {made, result_of(CODE_BS, KIND_BYTE)};
                  CHAR_LOWER_F: made = {made, result_of(CODE_FF, KIND_BYTE)};
                  CHAR_LOWER_U: begin
                     decode_mode = MODE_HEX;
                     digits_taken = 2'd0;
                     point_so_far = 16'h0000;
                  end
                  default: made = {made, result_of(item.in_byte, KIND_BYTE)};
               endcase
            end
            MODE_HEX: begin
               digit = digit_value(item.in_byte);
               if (digit[4]) begin
                  made = {made, result_of(8'h00, KIND_ERROR)};
                  back_to_plain();
               end else begin
                  point = {point_so_far[11:0], digit[3:0]};
                  point_so_far = point;
                  if (digits_taken != 2'd3) begin
                     digits_taken = digits_taken + 2'd1;
                  end else begin
                     if (point < 16'h0080) begin
                        made = {made, result_of(point[7:0], KIND_BYTE)};
                     end else if (point < 16'h0800) begin
                        made = {made, result_of({3'b110, point[10:6]}, KIND_BYTE)};
                        made = {made, result_of({2'b10, point[5:0]}, KIND_BYTE)};
                     end else begin
                        made = {made, result_of({4'b1110, point[15:12]}, KIND_BYTE)};
                        made = {made, result_of({2'b10, point[11:6]}, KIND_BYTE)};
                        made = {made, result_of({2'b10, point[5:0]}, KIND_BYTE)};
                     end
                     back_to_plain();
                  end
               end
            end
            default: begin
               if (item.in_byte == CHAR_QUOTE) begin
                  made = {made, result_of(8'h00, KIND_END)};
                  back_to_plain();
               end else if (item.in_byte == CHAR_BACKSLASH) begin
                  decode_mode = MODE_ESCAPE;
               end else begin
                  decode_mode = MODE_PLAIN;
                  made = {made, result_of(item.in_byte, KIND_BYTE)};
               end
            end
         endcase
      end
      if (made.size() > 0) begin
         made[made.size() - 1].last = 1'b1;
      end
      decoded_bytes = {decoded_bytes, made};
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         decoded_bytes.delete();
         back_to_plain();
         pending = 0;
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (decoded_bytes.size() == 0) begin
               $error("result item with none expected: out_byte %h kind %0d last %b",
                      rsp_item.out_byte, rsp_item.kind, rsp_item.last);
               fail_count++;
            end else begin
               want = decoded_bytes.pop_front();
               if (rsp_item.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %h, got %h", want.out_byte, rsp_item.out_byte);
                  fail_count++;
               end
               if (rsp_item.kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_item.kind);
                  fail_count++;
               end
               if (rsp_item.last !== want.last) begin
                  $error("last: expected %b, got %b", want.last, rsp_item.last);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            decode_item(req_item);
         end
         pending = decoded_bytes.size();
      end
   end

endmodule

[tb/testbench.sv]
// Top of the unescaper testbench: clock, reset, byte stimulus and result back-pressure.
// Checking is done by unescape_check. Depends on jsu_pkg, jsu_stream_if and the block.

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import jsu_pkg::*;

   localparam int LIMIT_CYCLES  = 100000;
   localparam int HOLD_CYCLES   = 60;
   localparam int PHASE_ITEMS   = 58;
   localparam int SETTLE_CYCLES = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   bit   hold_request = 1'b0;
   bit   hold_done = 1'b0;
   int   sent_count = 0;
   int   cycle_count = 0;
   int   pending;
   int   fail_count;

   jsu_stream_if #(.payload_type(req_type)) req_chan ();
   jsu_stream_if #(.payload_type(rsp_type)) rsp_chan ();

   json_string_unescape_utf8 dut (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

   unescape_check decode_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_item   (req_chan.payload),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_item   (rsp_chan.payload),
      .pending    (pending),
      .fail_count (fail_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold-off so the block backs up into its input.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Entered and left at a falling edge.
   task automatic send_item(input logic [7:0] b, input logic ended);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= '{in_byte: b, text_ended: ended};
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_item(s[i], 1'b0);
      end
   endtask

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      if (nibble < 4'd10) begin
         return 8'("0") + 8'(nibble);
      end
      return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(nibble) - 8'd10;
   endfunction

   function automatic logic [15:0] random_point();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 16'h007F));
         1: return 16'($urandom_range(16'h0080, 16'h07FF));
         2: return 16'($urandom_range(16'h0800, 16'hFFFF));
         default: begin
            // Boundaries between the one, two and three byte encodings, and surrogates.
            case ($urandom_range(0, 6))
               0: return 16'h0000;
               1: return 16'h007F;
               2: return 16'h0080;
               3: return 16'h07FF;
               4: return 16'h0800;
               5: return 16'($urandom_range(16'hD800, 16'hDFFF));
               default: return 16'hFFFF;
            endcase
         end
      endcase
   endfunction

   function automatic logic [7:0] escape_letter();
      logic [7:0] b;
      case ($urandom_range(0, 5))
         0: return CHAR_LOWER_N;
         1: return CHAR_LOWER_T;
         2: return CHAR_LOWER_R;
         3: return CHAR_LOWER_B;
         4: return CHAR_LOWER_F;
         default: begin
            do b = 8'($urandom_range(0, 255)); while (b == CHAR_LOWER_U);
            return b;
         end
      endcase
   endfunction

   task automatic send_unicode(input logic [15:0] point);
      send_item(CHAR_BACKSLASH, 1'b0);
      send_item(CHAR_LOWER_U, 1'b0);
      for (int i = 3; i >= 0; i--) begin
         send_item(hex_char(point[4 * i +: 4]), 1'b0);
      end
   endtask

   task automatic send_random_string();
      int         pieces;
      int         pick;
      logic [7:0] b;
      pieces = $urandom_range(0, 5);
      repeat (pieces) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            do b = 8'($urandom_range(0, 255));
            while (b == CHAR_QUOTE || b == CHAR_BACKSLASH);
            send_item(b, 1'b0);
         end else if (pick < 7) begin
            send_item(CHAR_BACKSLASH, 1'b0);
            send_item(escape_letter(), 1'b0);
         end else begin
            send_unicode(random_point());
         end
      end
      send_item(CHAR_QUOTE, 1'b0);
   endtask

   // Stray bytes, truncated text and broken unicode escapes.
   task automatic send_noise();
      int         digits;
      logic [7:0] b;
      case ($urandom_range(0, 4))
         0: send_item(8'($urandom_range(0, 255)), 1'b0);
         1: send_item(8'($urandom_range(0, 255)), 1'b1);
         2: begin
            send_item(CHAR_BACKSLASH, 1'b0);
            send_item(CHAR_LOWER_U, 1'b0);
            digits = $urandom_range(0, 3);
            repeat (digits) send_item(hex_char(4'($urandom_range(0, 15))), 1'b0);
            do b = 8'($urandom_range(0, 255)); while (is_hex(b));
            send_item(b, 1'b0);
         end
         3: begin
            send_item(CHAR_BACKSLASH, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1);
         end
         default: begin
            send_item(CHAR_BACKSLASH, 1'b0);
            send_item(CHAR_LOWER_U, 1'b0);
            digits = $urandom_range(0, 3);
            repeat (digits) send_item(hex_char(4'($urandom_range(0, 15))), 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1);
         end
      endcase
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input int count);
      int target;
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      target = sent_count + count;
      while (sent_count < target) begin
         if ($urandom_range(0, 99) < 80) begin
            send_random_string();
         end else begin
            send_noise();
         end
      end
   endtask

   // The sender goes idle first, so the last item is not offered again while waiting.
   task automatic wait_results_drained();
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Text ending before any byte, byte extremes, the closing quote and the n/t/r/b/f escapes.
      send_item(8'h00, 1'b1);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_text("\"");
      send_text("\\n\\t\\r\\b\\f");
      send_text("\\u0000");
      send_text("\\uD800");
      // A quote where a hex digit belongs is a malformed escape.
      send_text("\\u\"");
      wait_results_drained();

      hold_request = 1'b1;
      run_phase(0, 0, PHASE_ITEMS);
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (!hold_done);
      wait_results_drained();
      run_phase(49, 0, PHASE_ITEMS);
      wait_results_drained();
      run_phase(0, 49, PHASE_ITEMS);
      run_phase(22, 22, PHASE_ITEMS);

      wait_results_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
